>>> sv/tod_pkg.sv
// Shared types, constants and the sigmoid denominator function of the offload decision block.
// No dependencies; every other file imports this package.
package tod_pkg;

    localparam int TIME_W     = 16;
    localparam int ENERGY_W   = 20;
    localparam int FRAC_W     = 17;
    localparam int DBM_W      = 9;
    localparam int IDX_MAX_W  = 12;
    localparam int QUO_W      = 16;
    localparam int WGT_W      = 19;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 64;

    localparam logic [TIME_W-1:0] CRIT_DEADLINE_MS = 16'd100;
    localparam logic [FRAC_W-1:0] Q16_ONE          = 17'd65536;
    localparam logic [FRAC_W-1:0] Q16_HALF         = 17'd32768;
    localparam logic [FRAC_W-1:0] CONF_EDGE_LATE   = 17'd58982;

    localparam logic [WGT_W-1:0] W_TENTH = 19'd65536;
    localparam logic [WGT_W-1:0] W_BASE_TIME   = 19'd262144;
    localparam logic [WGT_W-1:0] W_BASE_ENERGY = 19'd262144;
    localparam logic [WGT_W-1:0] W_BASE_RISK   = 19'd131072;
    localparam logic [WGT_W-1:0] W_CRIT_TIME   = 19'd458752;

    // divide by 5 * 65536: reciprocal of 5 exact for values below 2^22
    localparam int           CONF_SHIFT   = 16;
    localparam logic [21:0]  CONF_SAT_LIM = 22'd327680;
    localparam logic [19:0]  RECIP5_MUL   = 20'd838861;
    localparam int           RECIP5_SHIFT = 22;

    typedef enum logic [2:0] {
        RSN_CRITICAL    = 3'd0,
        RSN_EDGE_ABSENT = 3'd1,
        RSN_EDGE_LATE   = 3'd2,
        RSN_BOTH_LATE   = 3'd3,
        RSN_LOCAL_BEST  = 3'd4,
        RSN_EDGE_BEST   = 3'd5
    } t_reason;

    typedef enum logic [1:0] {
        NC_DIV  = 2'd0,
        NC_ZERO = 2'd1,
        NC_FULL = 2'd2,
        NC_HALF = 2'd3
    } t_ncode;

    typedef enum logic [2:0] {
        CFG_TIME_FLOOR     = 3'd0,
        CFG_TIME_CEILING   = 3'd1,
        CFG_ENERGY_FLOOR   = 3'd2,
        CFG_ENERGY_CEILING = 3'd3,
        CFG_BATTERY_LOW    = 3'd4,
        CFG_WEAK_SIGNAL    = 3'd5,
        CFG_HIGH_LOSS      = 3'd6
    } t_cfg_idx;

    // request beat, last field in the lowest bits
    typedef struct packed {
        logic [FRAC_W-1:0]       loss_fraction;
        logic signed [DBM_W-1:0] signal_dbm;
        logic [FRAC_W-1:0]       battery_fraction;
        logic                    edge_up;
        logic [FRAC_W-1:0]       edge_fail_prob;
        logic [FRAC_W-1:0]       local_fail_prob;
        logic [ENERGY_W-1:0]     edge_energy_mj;
        logic [ENERGY_W-1:0]     local_energy_mj;
        logic [TIME_W-1:0]       edge_time_ms;
        logic [TIME_W-1:0]       local_time_ms;
        logic [TIME_W-1:0]       deadline_ms;
        logic                    critical;
    } t_req;

    // result beat, last field in the lowest bits
    typedef struct packed {
        t_reason             reason_code;
        logic [FRAC_W-1:0]   confidence_q16;
        logic [ENERGY_W-1:0] chosen_energy_mj;
        logic [TIME_W-1:0]   chosen_time_ms;
        logic                run_remote;
    } t_rsp;

    localparam int RSP_W = $bits(t_rsp);

    // classified job handed from the front to the back
    typedef struct packed {
        logic                 crit;
        logic                 early;
        logic                 remote_e;
        logic [FRAC_W-1:0]    conf_e;
        t_reason              reason_e;
        logic [TIME_W-1:0]    lt;
        logic [TIME_W-1:0]    et;
        logic [ENERGY_W-1:0]  le;
        logic [ENERGY_W-1:0]  ee;
        logic [FRAC_W-1:0]    lf;
        logic [FRAC_W-1:0]    ef;
        logic                 low_batt;
        logic                 weak_sig;
        logic                 lossy;
        logic [IDX_MAX_W-1:0] bidx;
        logic [IDX_MAX_W-1:0] sidx;
        logic [IDX_MAX_W-1:0] lidx;
        t_ncode               nc_tl;
        t_ncode               nc_te;
        t_ncode               nc_el;
        t_ncode               nc_ee;
        logic [TIME_W-1:0]    num_tl;
        logic [TIME_W-1:0]    num_te;
        logic [ENERGY_W-1:0]  num_el;
        logic [ENERGY_W-1:0]  num_ee;
        logic [TIME_W-1:0]    den_t;
        logic [ENERGY_W-1:0]  den_e;
    } t_job;

    typedef struct packed {
        t_job             job;
        logic [WGT_W-1:0] wt;
        logic [WGT_W-1:0] we;
        logic [WGT_W-1:0] wr;
    } t_ctx;

    // fields that ride along to the output stage
    typedef struct packed {
        logic                early;
        logic                remote_e;
        logic [FRAC_W-1:0]   conf_e;
        t_reason             reason_e;
        logic [TIME_W-1:0]   lt;
        logic [TIME_W-1:0]   et;
        logic [ENERGY_W-1:0] le;
        logic [ENERGY_W-1:0] ee;
    } t_pass;

    // sigmoid denominator 2^32 + e at entry idx; eh is the Q32 decay per entry
    function automatic logic [63:0] sig_den(input logic [63:0] eh, input int idx);
        logic [63:0] e;
        e = 64'd1 << 32;
        for (int i = 0; i < idx; i++) begin
            e = (e * eh + (64'd1 << 31)) >> 32;
        end
        return (64'd1 << 32) + e;
    endfunction

endpackage

>>> sv/tod_fifo.sv
// Short job queue between the classifying front and the scoring back.
// Depends on tod_pkg (t_job, QUEUE_DEPTH).
module tod_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tod_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output tod_pkg::t_job o_head
);
    import tod_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_job          r_mem [0:QUEUE_DEPTH-1];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{AW{1'b0}}, i_push} - {{AW{1'b0}}, i_pop};
        end
    end

    // hold job entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

>>> sv/tod_front.sv
// Front end: configuration registers, request register and classification into jobs.
// Depends on tod_pkg (request, job, codes).
module tod_front #(
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [tod_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [tod_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  tod_pkg::t_req                       i_req,
    input  logic                                i_q_full,
    output logic                                o_push,
    output tod_pkg::t_job                       o_job
);
    import tod_pkg::*;

    localparam int IDXW = $clog2(SIGMOID_ENTRIES);
    localparam int BMUL = 20 * SIGMOID_ENTRIES;
    localparam int BPW  = FRAC_W + $clog2(BMUL + 1);
    localparam int SHW  = BPW - 19;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(SIGMOID_ENTRIES - 1);

    logic [TIME_W-1:0]       r_tf;
    logic [TIME_W-1:0]       r_tc;
    logic [ENERGY_W-1:0]     r_ef;
    logic [ENERGY_W-1:0]     r_ec;
    logic [FRAC_W-1:0]       r_bll;
    logic signed [DBM_W-1:0] r_wsd;
    logic [FRAC_W-1:0]       r_hlr;

    logic r_v;
    t_req r_req;

    logic [FRAC_W-1:0]     b_dd;
    logic [FRAC_W-1:0]     l_dd;
    logic [BPW-1:0]        b_prod;
    logic [BPW-1:0]        l_prod;
    logic signed [DBM_W:0] s_dd;
    logic                  s_far;
    logic [IDXW-1:0]       sig_tbl [0:127];
    logic [IDXW-1:0]       s_idx;
    t_job                  cls;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tf  <= 16'd10;
            r_tc  <= 16'd5000;
            r_ef  <= 20'd100;
            r_ec  <= 20'd50000;
            r_bll <= 17'd13107;
            r_wsd <= -9'sd80;
            r_hlr <= 17'd6554;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_TIME_FLOOR:     r_tf  <= i_cfg_wdata[TIME_W-1:0];
                CFG_TIME_CEILING:   r_tc  <= i_cfg_wdata[TIME_W-1:0];
                CFG_ENERGY_FLOOR:   r_ef  <= i_cfg_wdata[ENERGY_W-1:0];
                CFG_ENERGY_CEILING: r_ec  <= i_cfg_wdata[ENERGY_W-1:0];
                CFG_BATTERY_LOW:    r_bll <= i_cfg_wdata[FRAC_W-1:0];
                CFG_WEAK_SIGNAL:    r_wsd <= $signed(i_cfg_wdata[DBM_W-1:0]);
                CFG_HIGH_LOSS:      r_hlr <= i_cfg_wdata[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // hold the request until the queue takes its job
    assign o_ready = !r_v || !i_q_full;
    assign o_push  = r_v && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

    // saturate a scaled fraction difference to a table index
    function automatic logic [IDXW-1:0] sat_idx(input logic [BPW-1:0] p);
        logic [SHW-1:0] hi;
        hi = p[BPW-1:19];
        return (hi > SHW'(SIGMOID_ENTRIES - 1)) ? IDX_LAST : hi[IDXW-1:0];
    endfunction

    function automatic t_ncode ncode(input logic [ENERGY_W-1:0] v,
                                     input logic [ENERGY_W-1:0] lo,
                                     input logic [ENERGY_W-1:0] hi);
        t_ncode c;
        priority if (hi <= lo) c = NC_HALF;
        else if (v <= lo)      c = NC_ZERO;
        else if (v >= hi)      c = NC_FULL;
        else                   c = NC_DIV;
        return c;
    endfunction

    // signal index table: dBm below the level times entries / 80
    for (genvar g = 0; g < 128; g++) begin : g_stbl
        localparam int SV = (g < 80) ? (g * SIGMOID_ENTRIES) / 80 : SIGMOID_ENTRIES - 1;
        assign sig_tbl[g] = IDXW'(SV);
    end

    assign b_dd   = r_bll - r_req.battery_fraction;
    assign l_dd   = r_req.loss_fraction - r_hlr;
    assign b_prod = BPW'(b_dd) * BPW'(BMUL);
    assign l_prod = BPW'(l_dd) * BPW'(BMUL);
    assign s_dd   = {r_wsd[DBM_W-1], r_wsd} - {r_req.signal_dbm[DBM_W-1], r_req.signal_dbm};
    assign s_far  = (s_dd > 10'sd79);
    assign s_idx  = s_far ? IDX_LAST : sig_tbl[s_dd[6:0]];

    // classify: early exits, sigmoid indices, normalization operands
    always_comb begin
        cls          = '0;
        cls.crit     = r_req.critical;
        cls.lt       = r_req.local_time_ms;
        cls.et       = r_req.edge_time_ms;
        cls.le       = r_req.local_energy_mj;
        cls.ee       = r_req.edge_energy_mj;
        cls.lf       = r_req.local_fail_prob;
        cls.ef       = r_req.edge_fail_prob;
        cls.low_batt = r_req.battery_fraction < r_bll;
        cls.weak_sig = r_req.signal_dbm < r_wsd;
        cls.lossy    = r_req.loss_fraction > r_hlr;
        cls.bidx     = IDX_MAX_W'(sat_idx(b_prod));
        cls.sidx     = IDX_MAX_W'(s_idx);
        cls.lidx     = IDX_MAX_W'(sat_idx(l_prod));
        cls.nc_tl    = ncode(ENERGY_W'(r_req.local_time_ms), ENERGY_W'(r_tf), ENERGY_W'(r_tc));
        cls.nc_te    = ncode(ENERGY_W'(r_req.edge_time_ms), ENERGY_W'(r_tf), ENERGY_W'(r_tc));
        cls.nc_el    = ncode(r_req.local_energy_mj, r_ef, r_ec);
        cls.nc_ee    = ncode(r_req.edge_energy_mj, r_ef, r_ec);
        cls.num_tl   = r_req.local_time_ms - r_tf;
        cls.num_te   = r_req.edge_time_ms - r_tf;
        cls.num_el   = r_req.local_energy_mj - r_ef;
        cls.num_ee   = r_req.edge_energy_mj - r_ef;
        cls.den_t    = r_tc - r_tf;
        cls.den_e    = r_ec - r_ef;
        cls.remote_e = 1'b0;
        cls.conf_e   = Q16_ONE;
        cls.reason_e = RSN_CRITICAL;
        priority if (r_req.critical && (r_req.deadline_ms < CRIT_DEADLINE_MS)) begin
            cls.early    = 1'b1;
        end else if (!r_req.edge_up) begin
            cls.early    = 1'b1;
            cls.reason_e = RSN_EDGE_ABSENT;
        end else if (r_req.edge_time_ms > r_req.deadline_ms) begin
            cls.early = 1'b1;
            if (r_req.local_time_ms <= r_req.deadline_ms) begin
                cls.conf_e   = CONF_EDGE_LATE;
                cls.reason_e = RSN_EDGE_LATE;
            end else begin
                cls.remote_e = 1'b1;
                cls.conf_e   = Q16_HALF;
                cls.reason_e = RSN_BOTH_LATE;
            end
        end else begin
            cls.early = 1'b0;
        end
    end

    assign o_job = cls;

endmodule

>>> sv/tod_div.sv
// Pipelined restoring divider: quotient of num * 2^16 / den, one bit per stage.
// Depends on tod_pkg (QUO_W). Caller keeps num below den.
module tod_div #(
    parameter int NW = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [NW-1:0]             i_num,
    input  logic [NW-1:0]             i_den,
    output logic [tod_pkg::QUO_W-1:0] o_quo
);
    import tod_pkg::*;

    logic [NW-1:0]    r_rem [0:QUO_W-2];
    logic [NW-1:0]    r_den [0:QUO_W-2];
    logic [QUO_W-1:0] r_quo [0:QUO_W-1];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [NW-1:0]    rem_in;
        logic [NW-1:0]    den_in;
        logic [QUO_W-1:0] quo_in;
        logic [NW+1:0]    trial;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        // trial subtract of the doubled remainder
        assign trial = {1'b0, rem_in, 1'b0} - {2'b00, den_in};
        assign take  = !trial[NW+1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= {quo_in[QUO_W-2:0], take};
            end
        end

        if (s < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s] <= den_in;
                    r_rem[s] <= take ? trial[NW-1:0] : {rem_in[NW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

>>> sv/tod_back.sv
// Back end: weights from the sigmoid table, normalization divides, scores and confidence.
// Depends on tod_pkg and tod_div.
module tod_back #(
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  tod_pkg::t_job i_head,
    output logic          o_pop,
    input  logic          i_ready,
    output logic          o_valid,
    output tod_pkg::t_rsp o_rsp
);
    import tod_pkg::*;

    localparam int IDXW = $clog2(SIGMOID_ENTRIES);
    localparam logic [63:0] HQ = (64'd8 << 32) / 64'(SIGMOID_ENTRIES);
    localparam int PW = WGT_W + FRAC_W;
    localparam int SW = PW + 2;
    localparam int XW = SW - CONF_SHIFT;
    localparam int MW = 19 + 20;

    // exp(-8/entries) in Q32: ten floored Taylor terms
    localparam logic [63:0] TS0  = 64'd1 << 32;
    localparam logic [63:0] TS1  = ((TS0 * HQ) >> 32) / 64'd1;
    localparam logic [63:0] TS2  = ((TS1 * HQ) >> 32) / 64'd2;
    localparam logic [63:0] TS3  = ((TS2 * HQ) >> 32) / 64'd3;
    localparam logic [63:0] TS4  = ((TS3 * HQ) >> 32) / 64'd4;
    localparam logic [63:0] TS5  = ((TS4 * HQ) >> 32) / 64'd5;
    localparam logic [63:0] TS6  = ((TS5 * HQ) >> 32) / 64'd6;
    localparam logic [63:0] TS7  = ((TS6 * HQ) >> 32) / 64'd7;
    localparam logic [63:0] TS8  = ((TS7 * HQ) >> 32) / 64'd8;
    localparam logic [63:0] TS9  = ((TS8 * HQ) >> 32) / 64'd9;
    localparam logic [63:0] TS10 = ((TS9 * HQ) >> 32) / 64'd10;
    localparam logic [63:0] EH   = TS0 - TS1 + TS2 - TS3 + TS4 - TS5 + TS6 - TS7 + TS8
                                   - TS9 + TS10;

    logic [FRAC_W-1:0] rom [0:SIGMOID_ENTRIES-1];

    logic en;
    logic [FRAC_W-1:0] f_b;
    logic [FRAC_W-1:0] f_s;
    logic [FRAC_W-1:0] f_l;
    logic [FRAC_W-1:0] g_net;
    t_ctx ctx_c;

    logic             r_s1_v;
    t_ctx             r_s1;
    logic [QUO_W-1:0] r_dv;
    t_ctx             r_dctx [0:QUO_W-1];
    logic [QUO_W-1:0] q_tl;
    logic [QUO_W-1:0] q_te;
    logic [QUO_W-1:0] q_el;
    logic [QUO_W-1:0] q_ee;

    logic          r_p_v;
    t_pass         r_p_pass;
    logic [PW-1:0] r_p_lt;
    logic [PW-1:0] r_p_le;
    logic [PW-1:0] r_p_lr;
    logic [PW-1:0] r_p_et;
    logic [PW-1:0] r_p_ee;
    logic [PW-1:0] r_p_er;
    t_pass         d_pass;

    logic          r_a_v;
    t_pass         r_a_pass;
    logic [SW-1:0] r_a_sl;
    logic [SW-1:0] r_a_se;

    logic          r_c_v;
    t_pass         r_c_pass;
    logic          r_c_remote;
    logic          r_c_sat;
    logic [18:0]   r_c_x;
    logic          c_local;
    logic [SW-1:0] c_diff;
    logic [XW-1:0] c_x;

    logic          r_o_v;
    t_rsp          r_o_rsp;
    logic [MW-1:0] o_mul;
    t_rsp          o_c;

    // sigmoid table, built at elaboration
    for (genvar i = 0; i < SIGMOID_ENTRIES; i++) begin : g_rom
        localparam logic [63:0] DEN = sig_den(EH, i);
        localparam logic [63:0] QV  = ((64'd1 << 48) + (DEN >> 1)) / DEN;
        localparam logic [FRAC_W-1:0] RV = QV[FRAC_W-1:0];
        assign rom[i] = RV;
    end

    // whole back pipeline moves unless the output beat is stuck
    assign en    = !r_o_v || i_ready;
    assign o_pop = en && !i_q_empty;

    // pick weights for the popped job
    always_comb begin
        f_b   = rom[i_head.bidx[IDXW-1:0]];
        f_s   = rom[i_head.sidx[IDXW-1:0]];
        f_l   = rom[i_head.lidx[IDXW-1:0]];
        g_net = Q16_HALF;
        if (i_head.weak_sig && (f_s > g_net)) begin
            g_net = f_s;
        end
        if (i_head.lossy && (f_l > g_net)) begin
            g_net = f_l;
        end
        ctx_c.job = i_head;
        ctx_c.wt  = W_BASE_TIME;
        ctx_c.we  = W_BASE_ENERGY;
        ctx_c.wr  = W_BASE_RISK;
        if (i_head.low_batt) begin
            ctx_c.we = W_BASE_ENERGY + WGT_W'({f_b, 1'b0});
            ctx_c.wt = W_BASE_TIME - WGT_W'(f_b);
            ctx_c.wr = W_BASE_RISK - WGT_W'(f_b);
        end
        if (i_head.weak_sig || i_head.lossy) begin
            ctx_c.wr = W_BASE_RISK + WGT_W'(g_net) + WGT_W'({g_net, 1'b0});
            ctx_c.wt = W_BASE_TIME - WGT_W'(g_net);
            ctx_c.we = W_BASE_ENERGY - WGT_W'({g_net, 1'b0});
        end
        if (i_head.crit) begin
            ctx_c.wt = W_CRIT_TIME;
            ctx_c.we = W_TENTH;
            ctx_c.wr = W_BASE_RISK;
        end
    end

    // normalization divides, aligned with the context line
    tod_div #(.NW(TIME_W)) u_div_tl (
        .i_clk(i_clk), .i_en(en), .i_num(r_s1.job.num_tl), .i_den(r_s1.job.den_t), .o_quo(q_tl)
    );
    tod_div #(.NW(TIME_W)) u_div_te (
        .i_clk(i_clk), .i_en(en), .i_num(r_s1.job.num_te), .i_den(r_s1.job.den_t), .o_quo(q_te)
    );
    tod_div #(.NW(ENERGY_W)) u_div_el (
        .i_clk(i_clk), .i_en(en), .i_num(r_s1.job.num_el), .i_den(r_s1.job.den_e), .o_quo(q_el)
    );
    tod_div #(.NW(ENERGY_W)) u_div_ee (
        .i_clk(i_clk), .i_en(en), .i_num(r_s1.job.num_ee), .i_den(r_s1.job.den_e), .o_quo(q_ee)
    );

    function automatic logic [FRAC_W-1:0] nval(input t_ncode c, input logic [QUO_W-1:0] q);
        logic [FRAC_W-1:0] v;
        unique case (c)
            NC_DIV:  v = {1'b0, q};
            NC_ZERO: v = '0;
            NC_FULL: v = Q16_ONE;
            NC_HALF: v = Q16_HALF;
            default: v = Q16_HALF;
        endcase
        return v;
    endfunction

    // ride-along fields at the end of the divide line
    always_comb begin
        d_pass.early    = r_dctx[QUO_W-1].job.early;
        d_pass.remote_e = r_dctx[QUO_W-1].job.remote_e;
        d_pass.conf_e   = r_dctx[QUO_W-1].job.conf_e;
        d_pass.reason_e = r_dctx[QUO_W-1].job.reason_e;
        d_pass.lt       = r_dctx[QUO_W-1].job.lt;
        d_pass.et       = r_dctx[QUO_W-1].job.et;
        d_pass.le       = r_dctx[QUO_W-1].job.le;
        d_pass.ee       = r_dctx[QUO_W-1].job.ee;
    end

    // compare scores and take the difference
    assign c_local = r_a_sl < r_a_se;
    assign c_diff  = c_local ? (r_a_se - r_a_sl) : (r_a_sl - r_a_se);
    assign c_x     = c_diff[SW-1:CONF_SHIFT];

    // confidence and final selection
    assign o_mul = MW'(r_c_x) * MW'(RECIP5_MUL);
    always_comb begin
        if (r_c_pass.early) begin
            o_c.run_remote     = r_c_pass.remote_e;
            o_c.confidence_q16 = r_c_pass.conf_e;
            o_c.reason_code    = r_c_pass.reason_e;
        end else begin
            o_c.run_remote     = r_c_remote;
            o_c.confidence_q16 = r_c_sat ? Q16_ONE : FRAC_W'(o_mul >> RECIP5_SHIFT);
            o_c.reason_code    = r_c_remote ? RSN_EDGE_BEST : RSN_LOCAL_BEST;
        end
        o_c.chosen_time_ms   = o_c.run_remote ? r_c_pass.et : r_c_pass.lt;
        o_c.chosen_energy_mj = o_c.run_remote ? r_c_pass.ee : r_c_pass.le;
    end

    // advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_dv   <= '0;
            r_p_v  <= 1'b0;
            r_a_v  <= 1'b0;
            r_c_v  <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (en) begin
            r_s1_v <= o_pop;
            r_dv   <= {r_dv[QUO_W-2:0], r_s1_v};
            r_p_v  <= r_dv[QUO_W-1];
            r_a_v  <= r_p_v;
            r_c_v  <= r_a_v;
            r_o_v  <= r_c_v;
        end
    end

    // advance stage payloads
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1      <= ctx_c;
            r_dctx[0] <= r_s1;
            for (int k = 1; k < QUO_W; k++) begin
                r_dctx[k] <= r_dctx[k-1];
            end
            r_p_pass <= d_pass;
            r_p_lt <= PW'(r_dctx[QUO_W-1].wt) * PW'(nval(r_dctx[QUO_W-1].job.nc_tl, q_tl));
            r_p_le <= PW'(r_dctx[QUO_W-1].we) * PW'(nval(r_dctx[QUO_W-1].job.nc_el, q_el));
            r_p_lr <= PW'(r_dctx[QUO_W-1].wr) * PW'(r_dctx[QUO_W-1].job.lf);
            r_p_et <= PW'(r_dctx[QUO_W-1].wt) * PW'(nval(r_dctx[QUO_W-1].job.nc_te, q_te));
            r_p_ee <= PW'(r_dctx[QUO_W-1].we) * PW'(nval(r_dctx[QUO_W-1].job.nc_ee, q_ee));
            r_p_er <= PW'(r_dctx[QUO_W-1].wr) * PW'(r_dctx[QUO_W-1].job.ef);
            r_a_pass <= r_p_pass;
            r_a_sl   <= SW'(r_p_lt) + SW'(r_p_le) + SW'(r_p_lr);
            r_a_se   <= SW'(r_p_et) + SW'(r_p_ee) + SW'(r_p_er);
            r_c_pass   <= r_a_pass;
            r_c_remote <= !c_local;
            r_c_sat    <= (c_x >= XW'(CONF_SAT_LIM));
            r_c_x      <= c_x[18:0];
            r_o_rsp    <= o_c;
        end
    end

    assign o_valid = r_o_v;
    assign o_rsp   = r_o_rsp;

endmodule

>>> sv/task_offload_decision.sv
// Top level of the offload decision block: stream ports, front, job queue and back.
// Depends on tod_pkg, tod_front, tod_fifo, tod_back (and tod_div below it).
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready  | i_s_tdata, request fields
//  m       | out | o_m_tvalid / i_m_tready  | o_m_tdata, decision fields
//  cfg     | in  | i_cfg_wr_en              | i_cfg_addr, i_cfg_wdata
//
// One request beat per cycle while the queue has room; a result passes through
// the 16-stage restoring divides that normalize time and energy.
// Synchronous active-low reset clears the valids and the queue; configuration
// returns to its defaults. A stalled result freezes the back; the four-entry queue
// and the request register keep taking beats until they fill.
module task_offload_decision #(
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [tod_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [tod_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // critical, deadline_ms, local_time_ms, edge_time_ms, local_energy_mj,
    // edge_energy_mj, local_fail_prob, edge_fail_prob, edge_up,
    // battery_fraction, signal_dbm, loss_fraction, zero pad
    input  logic [tod_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // run_remote, chosen_time_ms, chosen_energy_mj, confidence_q16,
    // reason_code, zero pad
    output logic [tod_pkg::OUT_DATA_W-1:0]    o_m_tdata
);
    import tod_pkg::*;

    t_req req;
    t_job push_job;
    t_job head_job;
    t_rsp rsp;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // unpack the request beat
    assign req = t_req'(i_s_tdata[$bits(t_req)-1:0]);

    tod_front #(.SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_req       (req),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    tod_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    tod_back #(.SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head_job),
        .o_pop     (pop),
        .i_ready   (i_m_tready),
        .o_valid   (o_m_tvalid),
        .o_rsp     (rsp)
    );

    // pack the result beat
    assign o_m_tdata = {{(OUT_DATA_W - RSP_W){1'b0}}, rsp};

    // local results come from local reasons, edge results from edge reasons
    a_side_matches_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (rsp.reason_code == RSN_BOTH_LATE || rsp.reason_code == RSN_EDGE_BEST)
        |-> rsp.run_remote)
        else $error("edge reason with local result");

    a_local_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (rsp.reason_code == RSN_CRITICAL || rsp.reason_code == RSN_EDGE_ABSENT ||
                       rsp.reason_code == RSN_EDGE_LATE || rsp.reason_code == RSN_LOCAL_BEST)
        |-> !rsp.run_remote)
        else $error("local reason with edge result");

    // forced exits carry full confidence
    a_exit_conf : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (rsp.reason_code == RSN_CRITICAL || rsp.reason_code == RSN_EDGE_ABSENT)
        |-> rsp.confidence_q16 == Q16_ONE)
        else $error("forced exit without full confidence");

    // the queue never overflows or underflows
    a_queue_bounds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full) && !(pop && q_empty))
        else $error("queue push when full or pop when empty");

endmodule
